FILE: hdl/teq_pkg.sv
// ----------------------------------------------------------------------------
// teq_pkg
// Types, sizes and command codes shared by the timed event queue modules.
// ----------------------------------------------------------------------------
package teq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int ID_BITS     = 8;
  localparam int TAG_BITS    = 16;

  localparam int IDX_W  = $clog2(QUEUE_DEPTH);
  localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int TIME_W = 64;
  localparam int AMT_W  = 32;

  localparam int F_CMD_W   = 3;
  localparam int F_ID_W    = 8;
  localparam int F_TAG_W   = 16;
  localparam int F_COUNT_W = 7;

  localparam int IN_DATA_W  = 56;
  localparam int OUT_DATA_W = 224;

  localparam logic [F_CMD_W-1:0] CMD_TICK   = 3'd0;
  localparam logic [F_CMD_W-1:0] CMD_ADD    = 3'd1;
  localparam logic [F_CMD_W-1:0] CMD_CANCEL = 3'd2;
  localparam logic [F_CMD_W-1:0] CMD_RUN    = 3'd3;
  localparam logic [F_CMD_W-1:0] CMD_ZERO   = 3'd4;

  typedef struct packed {
    logic [TIME_W-1:0]   due;
    logic [ID_BITS-1:0]  id;
    logic [TAG_BITS-1:0] tag;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic               re;
    logic [IDX_W-1:0]   raddr;
    logic               we;
    logic [IDX_W-1:0]   waddr;
    entry_t             wdata;
  } mem_req_t;

  typedef struct packed {
    logic [F_CMD_W-1:0] cmd;
    logic [AMT_W-1:0]   amount;
    logic [F_ID_W-1:0]  event_id;
    logic [F_TAG_W-1:0] event_tag;
  } cmd_item_t;

  typedef struct packed {
    logic                 fired;
    logic [F_ID_W-1:0]    fired_id;
    logic [F_TAG_W-1:0]   fired_tag;
    logic [TIME_W-1:0]    fired_time;
    logic                 last;
    logic                 status;
    logic [F_COUNT_W-1:0] queue_count;
    logic [TIME_W-1:0]    next_time;
    logic [TIME_W-1:0]    now_time;
  } result_t;

endpackage

FILE: hdl/teq_ram.sv
// ----------------------------------------------------------------------------
// teq_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module teq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: hdl/teq_seq.sv
// ----------------------------------------------------------------------------
// teq_seq
// Command sequencer: walks the sorted event memory one entry at a time for
// add, cancel and run, and holds the result register.
// ----------------------------------------------------------------------------
module teq_seq (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  teq_pkg::cmd_item_t in_item,
  output logic               out_valid,
  input  logic               out_ready,
  output teq_pkg::result_t   out_item,
  output teq_pkg::mem_req_t  mem_req,
  input  teq_pkg::entry_t    mem_rdata
);
  import teq_pkg::*;

  typedef enum logic [11:0] {
    S_IDLE  = 12'b000000000001,
    S_A_RD  = 12'b000000000010,
    S_A_CHK = 12'b000000000100,
    S_A_WR0 = 12'b000000001000,
    S_C_RD  = 12'b000000010000,
    S_C_CHK = 12'b000000100000,
    S_R_RD  = 12'b000001000000,
    S_R_CHK = 12'b000010000000,
    S_E_RD  = 12'b000100000000,
    S_E_CHK = 12'b001000000000,
    S_M_RD  = 12'b010000000000,
    S_M_CHK = 12'b100000000000
  } state_t;

  state_t              state_r, state_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [TIME_W-1:0]   now_r, now_nxt;
  logic [TIME_W-1:0]   head_r, head_nxt;
  logic [TIME_W-1:0]   t_r, t_nxt;
  logic [ID_BITS-1:0]  id_r, id_nxt;
  logic [TAG_BITS-1:0] tag_r, tag_nxt;
  logic [CNT_W-1:0]    idx_r, idx_nxt;
  logic [CNT_W-1:0]    wr_r, wr_nxt;
  logic [CNT_W-1:0]    ndue_r, ndue_nxt;
  logic                out_valid_r, out_valid_nxt;
  result_t             out_r, out_nxt;

  logic                emit;
  logic                em_fired;
  logic                em_last;
  logic                em_status;
  entry_t              em_entry;
  logic [CNT_W-1:0]    em_cnt;
  logic [TIME_W-1:0]   em_head;
  logic [CNT_W-1:0]    idx_p1;
  logic [CNT_W-1:0]    ndue_m1;
  logic                accept;
  logic                out_free;
  entry_t              new_entry;

  assign in_ready  = (state_r == S_IDLE) && !out_valid_r;
  assign accept    = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_item  = out_r;
  assign idx_p1    = idx_r + CNT_W'(1);
  assign ndue_m1   = ndue_r - CNT_W'(1);
  assign new_entry = '{due: t_r, id: id_r, tag: tag_r};

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    now_nxt   = now_r;
    head_nxt  = head_r;
    t_nxt     = t_r;
    id_nxt    = id_r;
    tag_nxt   = tag_r;
    idx_nxt   = idx_r;
    wr_nxt    = wr_r;
    ndue_nxt  = ndue_r;
    mem_req   = '0;
    emit      = 1'b0;
    em_fired  = 1'b0;
    em_last   = 1'b1;
    em_status = 1'b0;
    em_entry  = '0;
    em_cnt    = '0;
    em_head   = '0;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          t_nxt   = now_r + TIME_W'(in_item.amount);
          id_nxt  = ID_BITS'(in_item.event_id);
          tag_nxt = TAG_BITS'(in_item.event_tag);
          idx_nxt = '0;
          wr_nxt  = '0;
          case (in_item.cmd)
            CMD_TICK: begin
              now_nxt = now_r + TIME_W'(in_item.amount);
              emit    = 1'b1;
            end
            CMD_ADD: begin
              if (cnt_r == CNT_W'(QUEUE_DEPTH)) begin
                em_status = 1'b1;
                emit      = 1'b1;
              end else if (cnt_r == '0) begin
                mem_req.we    = 1'b1;
                mem_req.waddr = '0;
                mem_req.wdata = '{due: t_nxt, id: id_nxt, tag: tag_nxt};
                head_nxt      = t_nxt;
                cnt_nxt       = CNT_W'(1);
                emit          = 1'b1;
              end else begin
                idx_nxt   = cnt_r - CNT_W'(1);
                state_nxt = S_A_RD;
              end
            end
            CMD_CANCEL: begin
              if (cnt_r == '0) begin
                emit = 1'b1;
              end else begin
                state_nxt = S_C_RD;
              end
            end
            CMD_RUN: begin
              if (cnt_r == '0) begin
                emit = 1'b1;
              end else begin
                state_nxt = S_R_RD;
              end
            end
            CMD_ZERO: begin
              now_nxt = '0;
              emit    = 1'b1;
            end
            default: begin
              emit = 1'b1;
            end
          endcase
        end
      end

      // Insert walks down from the tail, moving each later entry up by one.
      S_A_RD: begin
        mem_req.re    = 1'b1;
        mem_req.raddr = idx_r[IDX_W-1:0];
        state_nxt     = S_A_CHK;
      end
      S_A_CHK: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = idx_p1[IDX_W-1:0];
        if (mem_rdata.due >= t_r) begin
          mem_req.wdata = mem_rdata;
          if (idx_r == '0) begin
            state_nxt = S_A_WR0;
          end else begin
            idx_nxt   = idx_r - CNT_W'(1);
            state_nxt = S_A_RD;
          end
        end else begin
          mem_req.wdata = new_entry;
          cnt_nxt       = cnt_r + CNT_W'(1);
          emit          = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      S_A_WR0: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = '0;
        mem_req.wdata = new_entry;
        head_nxt      = t_r;
        cnt_nxt       = cnt_r + CNT_W'(1);
        emit          = 1'b1;
        state_nxt     = S_IDLE;
      end

      // Cancel compacts the kept entries toward the head in one pass.
      S_C_RD: begin
        mem_req.re    = 1'b1;
        mem_req.raddr = idx_r[IDX_W-1:0];
        state_nxt     = S_C_CHK;
      end
      S_C_CHK: begin
        if (mem_rdata.id != id_r) begin
          mem_req.we    = 1'b1;
          mem_req.waddr = wr_r[IDX_W-1:0];
          mem_req.wdata = mem_rdata;
          if (wr_r == '0) begin
            head_nxt = mem_rdata.due;
          end
          wr_nxt = wr_r + CNT_W'(1);
        end
        idx_nxt = idx_p1;
        if (idx_p1 == cnt_r) begin
          cnt_nxt   = (mem_rdata.id != id_r) ? wr_r + CNT_W'(1) : wr_r;
          emit      = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_C_RD;
        end
      end

      // Run first counts the due prefix so every result knows the final count.
      S_R_RD: begin
        mem_req.re    = 1'b1;
        mem_req.raddr = idx_r[IDX_W-1:0];
        state_nxt     = S_R_CHK;
      end
      S_R_CHK: begin
        if (mem_rdata.due <= now_r) begin
          idx_nxt = idx_p1;
          if (idx_p1 == cnt_r) begin
            ndue_nxt  = cnt_r;
            idx_nxt   = '0;
            state_nxt = S_E_RD;
          end else begin
            state_nxt = S_R_RD;
          end
        end else begin
          ndue_nxt = idx_r;
          head_nxt = mem_rdata.due;
          if (idx_r == '0) begin
            emit      = 1'b1;
            state_nxt = S_IDLE;
          end else begin
            idx_nxt   = '0;
            state_nxt = S_E_RD;
          end
        end
      end
      S_E_RD: begin
        if (out_free) begin
          mem_req.re    = 1'b1;
          mem_req.raddr = idx_r[IDX_W-1:0];
          state_nxt     = S_E_CHK;
        end
      end
      S_E_CHK: begin
        emit     = 1'b1;
        em_fired = 1'b1;
        em_entry = mem_rdata;
        em_last  = (idx_r == ndue_m1);
        idx_nxt  = idx_p1;
        if (idx_r == ndue_m1) begin
          idx_nxt   = ndue_r;
          wr_nxt    = '0;
          state_nxt = S_M_RD;
        end else begin
          state_nxt = S_E_RD;
        end
      end
      S_M_RD: begin
        if (idx_r == cnt_r) begin
          cnt_nxt   = cnt_r - ndue_r;
          state_nxt = S_IDLE;
        end else begin
          mem_req.re    = 1'b1;
          mem_req.raddr = idx_r[IDX_W-1:0];
          state_nxt     = S_M_CHK;
        end
      end
      S_M_CHK: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = wr_r[IDX_W-1:0];
        mem_req.wdata = mem_rdata;
        wr_nxt        = wr_r + CNT_W'(1);
        idx_nxt       = idx_p1;
        state_nxt     = S_M_RD;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    em_cnt  = em_fired ? (cnt_r - ndue_r) : cnt_nxt;
    em_head = head_nxt;

    out_valid_nxt = out_valid_r && !out_ready;
    out_nxt       = out_r;
    if (emit) begin
      out_valid_nxt       = 1'b1;
      out_nxt.fired       = em_fired;
      out_nxt.fired_id    = F_ID_W'(em_entry.id);
      out_nxt.fired_tag   = F_TAG_W'(em_entry.tag);
      out_nxt.fired_time  = em_entry.due;
      out_nxt.last        = em_last;
      out_nxt.status      = em_status;
      out_nxt.queue_count = F_COUNT_W'(em_cnt);
      out_nxt.next_time   = (em_cnt != '0) ? em_head : '0;
      out_nxt.now_time    = now_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      now_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      now_r       <= now_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    head_r <= head_nxt;
    t_r    <= t_nxt;
    id_r   <= id_nxt;
    tag_r  <= tag_nxt;
    idx_r  <= idx_nxt;
    wr_r   <= wr_nxt;
    ndue_r <= ndue_nxt;
    out_r  <= out_nxt;
  end

endmodule

FILE: hdl/timed_event_queue.sv
// Tick, zero, a full add and any command on an empty queue give their item in the cycle
// after acceptance. Add moves each later entry up, then writes the new one (in its own step
// at the head). Cancel reads each entry and writes back the kept ones; run reads each due
// entry and the first not due, emits each due item (each waits for out_tready), then moves
// the rest down. One command at a time; the next is taken once its last item has left.
// Synchronous active-low reset empties the queue and zeroes the time.
// ----------------------------------------------------------------------------
// timed_event_queue
// Timed event queue kept sorted by due time in a small event RAM.
// ----------------------------------------------------------------------------
module timed_event_queue (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // amount, event_id, event_tag
  input  logic [teq_pkg::IN_DATA_W-1:0]      in_tdata,
  // cmd
  input  logic [teq_pkg::F_CMD_W-1:0]        in_tuser,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // fired_id, fired_tag, fired_time, queue_count, next_time, now_time, pad
  output logic [teq_pkg::OUT_DATA_W-1:0]     out_tdata,
  // fired, status
  output logic [1:0]                         out_tuser,
  output logic                               out_tlast
);
  import teq_pkg::*;

  cmd_item_t in_item;
  result_t   res;
  mem_req_t  mem_req;
  entry_t    mem_rdata;
  logic [ENTRY_W-1:0] rdata_raw;

  assign in_item.cmd       = in_tuser;
  assign in_item.amount    = in_tdata[31:0];
  assign in_item.event_id  = in_tdata[39:32];
  assign in_item.event_tag = in_tdata[55:40];

  assign out_tdata = {1'b0, res.now_time, res.next_time, res.queue_count,
                      res.fired_time, res.fired_tag, res.fired_id};
  assign out_tuser = {res.status, res.fired};
  assign out_tlast = res.last;
  assign mem_rdata = entry_t'(rdata_raw);

  teq_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_item   (in_item),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_item  (res),
    .mem_req   (mem_req),
    .mem_rdata (mem_rdata)
  );

  teq_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .re    (mem_req.re),
    .raddr (mem_req.raddr),
    .rdata (rdata_raw),
    .we    (mem_req.we),
    .waddr (mem_req.waddr),
    .wdata (mem_req.wdata)
  );

endmodule

FILE: hdl/teq_checker.sv
// ----------------------------------------------------------------------------
// teq_checker
// Port-level checks for the timed event queue, bound to the top level.
// ----------------------------------------------------------------------------
module teq_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_tvalid,
  input logic                           in_tready,
  input logic                           out_tvalid,
  input logic                           out_tready,
  input logic [teq_pkg::OUT_DATA_W-1:0] out_tdata,
  input logic [1:0]                     out_tuser,
  input logic                           out_tlast
);
  import teq_pkg::*;

  // A held result keeps its payload until taken.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata)
      && $stable(out_tuser) && $stable(out_tlast))
    else $error("result changed while stalled");

  // Only one command is in work at a time.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken while a command is in work");

  // A result that reports no fired event ends its command.
  a_nofire_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tlast)
    else $error("non-fired result not marked last");

  // A dropped add never reports a fired event, and the count stays in range.
  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tuser[1] && out_tuser[0])
      && (out_tdata[94:88] <= F_COUNT_W'(QUEUE_DEPTH)))
    else $error("bad status or queue count");

endmodule

bind timed_event_queue teq_checker u_teq_checker (.*);

FILE: tb/sv/teq_checker.sv
// ----------------------------------------------------------------------------
// tb_checker
// Watches both streams of the timed event queue, keeps its own sorted copy of
// the pending events and the running time, and compares every result item.
// ----------------------------------------------------------------------------
module tb_checker
  import teq_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic [F_CMD_W-1:0]    in_tuser,
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic [OUT_DATA_W-1:0] out_tdata,
  input  logic [1:0]            out_tuser,
  input  logic                  out_tlast,
  output int                    fail_count,
  output int                    results_waiting,
  output int                    results_seen,
  output int                    events_fired
);

  typedef struct {
    logic [TIME_W-1:0]   due;
    logic [ID_BITS-1:0]  id;
    logic [TAG_BITS-1:0] tag;
  } event_t;

  event_t            event_list[$];
  logic [TIME_W-1:0] clock_now;
  result_t           expected_results[$];

  initial begin
    fail_count      = 0;
    results_waiting = 0;
    results_seen    = 0;
    events_fired    = 0;
  end

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("MISMATCH result %0d: %s got %0h expected %0h", results_seen, what,
             got, want);
    fail_count++;
  endtask

  task automatic schedule_command(input logic [F_CMD_W-1:0] cmd,
                                  input logic [AMT_W-1:0] amount,
                                  input logic [F_ID_W-1:0] id,
                                  input logic [F_TAG_W-1:0] tag);
    result_t popped[$];
    result_t r;
    logic    dropped;
    int      pos;
    event_t  e;
    dropped = 1'b0;
    case (cmd)
      CMD_TICK: clock_now = clock_now + amount;
      CMD_ADD: begin
        if (event_list.size() >= QUEUE_DEPTH) begin
          dropped = 1'b1;
        end else begin
          e.due = clock_now + amount;
          e.id  = id[ID_BITS-1:0];
          e.tag = tag[TAG_BITS-1:0];
          pos = 0;
          while (pos < event_list.size() && event_list[pos].due < e.due) pos++;
          event_list.insert(pos, e);
        end
      end
      CMD_CANCEL: begin
        for (int k = event_list.size() - 1; k >= 0; k--)
          if (event_list[k].id == id[ID_BITS-1:0]) event_list.delete(k);
      end
      CMD_RUN: begin
        while (event_list.size() > 0 && event_list[0].due <= clock_now) begin
          r = '0;
          r.fired      = 1'b1;
          r.fired_id   = event_list[0].id;
          r.fired_tag  = event_list[0].tag;
          r.fired_time = event_list[0].due;
          popped.push_back(r);
          void'(event_list.pop_front());
        end
      end
      CMD_ZERO: clock_now = '0;
      default: ;
    endcase
    if (popped.size() == 0) begin
      r = '0;
      r.status = dropped;
      popped.push_back(r);
    end
    foreach (popped[k]) begin
      popped[k].last        = (k == popped.size() - 1);
      popped[k].queue_count = F_COUNT_W'(event_list.size());
      popped[k].next_time   = event_list.size() > 0 ? event_list[0].due : '0;
      popped[k].now_time    = clock_now;
      expected_results.push_back(popped[k]);
    end
  endtask

  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (!rst_n) begin
      event_list.delete();
      expected_results.delete();
      clock_now = '0;
    end else begin
      if (in_tvalid && in_tready)
        schedule_command(in_tuser, in_tdata[31:0], in_tdata[39:32], in_tdata[55:40]);
      if (out_tvalid && out_tready) begin
        got.fired       = out_tuser[0];
        got.status      = out_tuser[1];
        got.last        = out_tlast;
        got.fired_id    = out_tdata[7:0];
        got.fired_tag   = out_tdata[23:8];
        got.fired_time  = out_tdata[87:24];
        got.queue_count = out_tdata[94:88];
        got.next_time   = out_tdata[158:95];
        got.now_time    = out_tdata[222:159];
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result", 64'd1, 64'd0);
        end else begin
          want = expected_results.pop_front();
          if (got.fired != want.fired) report_mismatch("fired", got.fired, want.fired);
          if (got.fired_id != want.fired_id)
            report_mismatch("fired_id", got.fired_id, want.fired_id);
          if (got.fired_tag != want.fired_tag)
            report_mismatch("fired_tag", got.fired_tag, want.fired_tag);
          if (got.fired_time != want.fired_time)
            report_mismatch("fired_time", got.fired_time, want.fired_time);
          if (got.last != want.last) report_mismatch("last", got.last, want.last);
          if (got.status != want.status)
            report_mismatch("status", got.status, want.status);
          if (got.queue_count != want.queue_count)
            report_mismatch("queue_count", got.queue_count, want.queue_count);
          if (got.next_time != want.next_time)
            report_mismatch("next_time", got.next_time, want.next_time);
          if (got.now_time != want.now_time)
            report_mismatch("now_time", got.now_time, want.now_time);
          if (want.fired) events_fired++;
        end
        results_seen++;
      end
    end
    results_waiting = expected_results.size();
  end

endmodule

FILE: tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Stimulus for the timed event queue: directed corner commands, then random
// schedules of every command code, with idle gaps on both streams.
// ----------------------------------------------------------------------------
module tb;
  import teq_pkg::*;

  localparam int CYCLE_LIMIT = 400000;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic [F_CMD_W-1:0]    in_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [1:0]            out_tuser;
  logic                  out_tlast;
  int                    fail_count;
  int                    results_waiting;
  int                    results_seen;
  int                    events_fired;
  int                    cycle_count;
  int                    items_sent;
  logic                  calm;

  timed_event_queue i_dut (.*);

  tb_checker i_checker (.*);

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  initial begin
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = CMD_TICK;
    out_tready = 1'b0;
    calm       = 1'b0;
    cycle_count = 0;
    items_sent = 0;
  end

  // Result side stalls at random, except during the calm stretch.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    out_tready  <= calm || ($urandom_range(99) >= 22);
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Mismatches found");
      $finish;
    end
  end

  // Offers one item and holds it until the block takes it.
  task automatic send_item(input logic [F_CMD_W-1:0] cmd, input logic [AMT_W-1:0] amount,
                           input logic [F_ID_W-1:0] id, input logic [F_TAG_W-1:0] tag);
    while (!calm && $urandom_range(99) < 22) @(posedge clk);
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {tag, id, amount};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    in_tvalid <= 1'b0;
    items_sent++;
    // The block is always busy in the cycle after it takes an item.
    @(posedge clk);
  endtask

  task automatic random_command();
    int            pick;
    logic [31:0]   amount;
    logic [7:0]    id;
    pick = $urandom_range(99);
    amount = ($urandom_range(9) == 0) ? $urandom : $urandom_range(40);
    id = ($urandom_range(3) == 0) ? F_ID_W'($urandom) : F_ID_W'($urandom_range(5));
    if (pick < 40)      send_item(CMD_ADD, amount, id, F_TAG_W'($urandom));
    else if (pick < 62) send_item(CMD_TICK, amount, id, F_TAG_W'($urandom));
    else if (pick < 82)
      send_item(CMD_RUN, $urandom, F_ID_W'($urandom), F_TAG_W'($urandom));
    else if (pick < 93) send_item(CMD_CANCEL, $urandom, id, F_TAG_W'($urandom));
    else if (pick < 97)
      send_item(CMD_ZERO, $urandom, F_ID_W'($urandom), F_TAG_W'($urandom));
    else
      send_item(F_CMD_W'($urandom_range(7, 5)), $urandom, F_ID_W'($urandom),
                F_TAG_W'($urandom));
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: run on empty, extremes, equal times, full queue, cancels.
    send_item(CMD_RUN, 32'hFFFF_FFFF, 8'hFF, 16'hFFFF);
    send_item(CMD_ADD, 32'd0, 8'h00, 16'h0000);
    send_item(CMD_ADD, 32'd0, 8'hFF, 16'hFFFF);
    send_item(CMD_ADD, 32'hFFFF_FFFF, 8'h55, 16'hAAAA);
    send_item(CMD_RUN, 32'd0, 8'd0, 16'd0);
    send_item(CMD_CANCEL, 32'd0, 8'h77, 16'd0);
    send_item(CMD_CANCEL, 32'd0, 8'h55, 16'd0);
    for (int k = 0; k < 17; k++)
      send_item(CMD_ADD, k % 3, k % 2 ? 8'h01 : 8'h02, F_TAG_W'(k));
    send_item(CMD_CANCEL, 32'd0, 8'h01, 16'd0);
    repeat (20) send_item(CMD_TICK, 32'hFFFF_FFFF, 8'd0, 16'd0);
    send_item(CMD_RUN, 32'd0, 8'd0, 16'd0);
    send_item(CMD_TICK, 32'hFFFF_FFFF, 8'd0, 16'd0);
    send_item(CMD_ADD, 32'hFFFF_FFFF, 8'h09, 16'h1234);
    send_item(CMD_ZERO, 32'd0, 8'd0, 16'd0);
    send_item(3'd5, 32'd0, 8'd0, 16'd0);
    send_item(3'd7, 32'd0, 8'd0, 16'd0);
    send_item(CMD_RUN, 32'd0, 8'd0, 16'd0);

    // Let every result drain before the random part.
    while (results_waiting != 0) @(posedge clk);

    for (int n = 0; n < 408; n++) begin
      calm = (n >= 150 && n < 220);
      random_command();
    end
    calm = 1'b0;

    while (results_waiting != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("Sent %0d commands, checked %0d results, %0d of them fired events.",
             items_sent, results_seen, events_fired);
    if (fail_count == 0 && results_waiting == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
